>>> src/swd_bit_sequencer_unit_defines.svh
// Assertion helpers for the sequencer checker.
`ifndef SWD_BIT_SEQUENCER_UNIT_DEFINES_SVH
`define SWD_BIT_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset
`define SWD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swd sequencer check failed");

// Next-cycle implication, held off during reset
`define SWD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swd sequencer check failed");

`endif

>>> src/swd_pkg.sv
`timescale 1ns / 1ps
package swd_pkg;

  localparam int MAX_BITS = 32;
  // Counter holds 0..MAX_BITS (parity slot sits at index MAX_BITS)
  localparam int CNT_W = $clog2(MAX_BITS + 1);
  localparam int IDX_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_READ_PAR  = 2'd1,
    OP_WRITE     = 2'd2,
    OP_WRITE_PAR = 2'd3
  } opcode_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit_turn;
    logic emit_bit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic turn_needed;
    logic last_bit;
    logic out_free;
  } stat_t;

endpackage

>>> src/swd_ctrl.sv
`timescale 1ns / 1ps
module swd_ctrl
  import swd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TURN = 3'b010,
    ST_BITS = 3'b100
  } state_t;

  state_t state, state_next;

  // Take a new request only while idle
  assign in_stall = (state != ST_IDLE);

  // Sequence turnaround and bit periods, one per free output slot
  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.turn_needed ? ST_TURN : ST_BITS;
        end
      end
      ST_TURN: begin
        if (stat.out_free) begin
          cmd.emit_turn = 1'b1;
          state_next    = ST_BITS;
        end
      end
      ST_BITS: begin
        if (stat.out_free) begin
          cmd.emit_bit = 1'b1;
          if (stat.last_bit) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

>>> src/swd_datapath.sv
`timescale 1ns / 1ps
module swd_datapath
  import swd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  opcode,
  input  logic [5:0]  bit_count,
  input  logic [31:0] write_data,
  input  logic [32:0] target_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        line_level,
  output logic        drive_enable,
  output logic        turnaround,
  output logic        last,
  output logic [31:0] read_data,
  output logic        parity_error
);

  logic             line_driven;
  logic             is_write;
  logic             with_par;
  logic [CNT_W-1:0] last_idx;
  logic [CNT_W-1:0] idx;
  logic [31:0]      wshift;
  logic [32:0]      tshift;
  logic             par;
  logic [31:0]      word;

  logic             op_write;
  logic             op_par;
  logic [CNT_W-1:0] n_sat;
  logic             par_slot;
  logic             bit_val;
  logic [31:0]      word_cur;

  // Decode the incoming request
  assign op_write = (opcode == OP_WRITE) || (opcode == OP_WRITE_PAR);
  assign op_par   = (opcode == OP_READ_PAR) || (opcode == OP_WRITE_PAR);

  // Clamp the bit count to 1..MAX_BITS
  always_comb begin
    if (bit_count == 6'd0)                    n_sat = CNT_W'(1);
    else if ({1'b0, bit_count} > 7'(MAX_BITS)) n_sat = CNT_W'(MAX_BITS);
    else                                      n_sat = CNT_W'(bit_count);
  end

  // Current bit period
  assign par_slot = with_par && (idx == last_idx);
  assign bit_val  = is_write ? (par_slot ? par : wshift[0]) : tshift[0];

  // Read word with the current data bit merged in
  always_comb begin
    word_cur = word;
    if (!par_slot && bit_val) word_cur[idx[IDX_W-1:0]] = 1'b1;
  end

  assign stat.turn_needed = (op_write != line_driven);
  assign stat.last_bit    = (idx == last_idx);
  assign stat.out_free    = !out_valid || !out_stall;

  // Load the request and advance one bit per emitted period
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_write <= op_write;
      with_par <= op_par;
      last_idx <= n_sat - CNT_W'(1) + CNT_W'(op_par);
      idx      <= '0;
      wshift   <= write_data;
      tshift   <= target_bits;
      par      <= 1'b0;
      word     <= '0;
    end else if (cmd.emit_bit) begin
      idx      <= idx + CNT_W'(1);
      wshift   <= wshift >> 1;
      tshift   <= tshift >> 1;
      par      <= par ^ bit_val;
      word     <= word_cur;
    end
  end

  // Remember line direction after the final period
  always_ff @(posedge clk) begin
    if (rst)                                line_driven <= 1'b0;
    else if (cmd.emit_bit && stat.last_bit) line_driven <= is_write;
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst)                                 out_valid <= 1'b0;
    else if (cmd.emit_turn || cmd.emit_bit)  out_valid <= 1'b1;
    else if (!out_stall)                     out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_turn) begin
      line_level   <= 1'b0;
      drive_enable <= is_write;
      turnaround   <= 1'b1;
      last         <= 1'b0;
      read_data    <= '0;
      parity_error <= 1'b0;
    end else if (cmd.emit_bit) begin
      line_level   <= bit_val;
      drive_enable <= is_write;
      turnaround   <= 1'b0;
      last         <= stat.last_bit;
      read_data    <= (!is_write && stat.last_bit) ? word_cur : '0;
      parity_error <= !is_write && stat.last_bit && with_par && (par ^ bit_val);
    end
  end

endmodule

>>> src/swd_bit_sequencer_unit.sv
`timescale 1ns / 1ps
// Channel  | Handshake              | Payload
// in       | in_valid / in_stall    | opcode, bit_count, write_data, target_bits
// out      | out_valid / out_stall  | line_level, drive_enable, turnaround, last,
//          |                        | read_data, parity_error
// A request is accepted, then gives its results: a turnaround on a change of line
// direction, bit_count data periods (clamped to 1..32), then parity if requested.
// Up to 34 results; the result rate is set by the single output register.
// out_stall holds the sequencer in place; in_stall stays high until the last
// result is in the output register. Reset records the line as undriven.
module swd_bit_sequencer_unit
  import swd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [5:0]  bit_count,
  input  logic [31:0] write_data,
  input  logic [32:0] target_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        line_level,
  output logic        drive_enable,
  output logic        turnaround,
  output logic        last,
  output logic [31:0] read_data,
  output logic        parity_error
);

  cmd_t  cmd;
  stat_t stat;

  swd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  swd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .bit_count    (bit_count),
    .write_data   (write_data),
    .target_bits  (target_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_level   (line_level),
    .drive_enable (drive_enable),
    .turnaround   (turnaround),
    .last         (last),
    .read_data    (read_data),
    .parity_error (parity_error)
  );

endmodule

>>> src/swd_checker.sv
`timescale 1ns / 1ps
`include "swd_bit_sequencer_unit_defines.svh"
module swd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        line_level,
  input logic        drive_enable,
  input logic        turnaround,
  input logic        last,
  input logic [31:0] read_data,
  input logic        parity_error
);

  // Turnaround period carries no level and never ends a request
  `SWD_ASSERT_IMPL(a_turn_quiet, out_valid && turnaround, !line_level && !last)

  // Read word and parity flag only on the last period of a read
  `SWD_ASSERT_IMPL(a_rdata_zero, out_valid && (!last || drive_enable), ~|{read_data, parity_error})

  // A stalled result holds
  `SWD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({last, line_level}))

  // A request accepted raises in_stall, blocking the next one
  `SWD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind swd_bit_sequencer_unit swd_checker u_swd_checker (.*);

>>> tb/swd_bit_sequencer_unit_test.sv
`timescale 1ns / 1ps
module swd_bit_sequencer_unit_test;
  import swd_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_OFF     = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_REQS  = 140;

  typedef struct packed {
    opcode_t     op;
    logic [5:0]  bits;
    logic [31:0] wdata;
    logic [32:0] tbits;
  } swd_req_t;

  // One directed request; gold_len of zero means no typed-in answer
  typedef struct packed {
    swd_req_t    req;
    int          gold_len;
    logic [31:0] gold_rdata;
    logic        gold_perr;
  } swd_row_t;

  // One SWD clock period as the line should show it
  typedef struct packed {
    logic        level;
    logic        drive;
    logic        turn;
    logic        last;
    logic [31:0] rdata;
    logic        perr;
    int          row;
  } line_period_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = OP_READ;
  logic [5:0]  bit_count = 6'd1;
  logic [31:0] write_data = '0;
  logic [32:0] target_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        line_level;
  logic        drive_enable;
  logic        turnaround;
  logic        last;
  logic [31:0] read_data;
  logic        parity_error;

  line_period_t periods_due[$];
  swd_row_t     script[$];
  logic         line_owned = 1'b0;
  int           cur_row = -1;
  int           period_idx = 0;
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           calm = 1'b0;
  bit           hold_off_req = 1'b0;

  swd_bit_sequencer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .bit_count    (bit_count),
    .write_data   (write_data),
    .target_bits  (target_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_level   (line_level),
    .drive_enable (drive_enable),
    .turnaround   (turnaround),
    .last         (last),
    .read_data    (read_data),
    .parity_error (parity_error)
  );

  always #1 clk = ~clk;

  // Pick an idle stretch: mostly none or short, now and then long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic void queue_period(input logic level, input logic drive,
                                       input logic turn, input logic lst,
                                       input logic [31:0] rdata, input logic perr,
                                       input int row);
    line_period_t p;
    p.level = level;
    p.drive = drive;
    p.turn  = turn;
    p.last  = lst;
    p.rdata = rdata;
    p.perr  = perr;
    p.row   = row;
    periods_due.push_back(p);
  endfunction

  // Work out the line periods of one request and track who owns the line
  function automatic void predict_periods(input swd_req_t r, input int row);
    int          n;
    int          total;
    logic        par;
    logic        b;
    logic [31:0] word;
    bit          writing;
    bit          with_par;
    n = int'(r.bits);
    if (n == 0) n = 1;
    if (n > MAX_BITS) n = MAX_BITS;
    writing  = (r.op == OP_WRITE) || (r.op == OP_WRITE_PAR);
    with_par = (r.op == OP_READ_PAR) || (r.op == OP_WRITE_PAR);
    par  = 1'b0;
    word = '0;
    if (writing) begin
      // probe takes the line: turnaround with the driver on
      if (!line_owned) queue_period(1'b0, 1'b1, 1'b1, 1'b0, '0, 1'b0, row);
      for (int i = 0; i < n; i++) begin
        b = r.wdata[i];
        par ^= b;
        queue_period(b, 1'b1, 1'b0, !with_par && (i == n - 1), '0, 1'b0, row);
      end
      if (with_par) queue_period(par, 1'b1, 1'b0, 1'b1, '0, 1'b0, row);
      line_owned = 1'b1;
    end else begin
      total = n + (with_par ? 1 : 0);
      // target takes the line: turnaround with the driver off
      if (line_owned) queue_period(1'b0, 1'b0, 1'b1, 1'b0, '0, 1'b0, row);
      for (int i = 0; i < total; i++) begin
        b = r.tbits[i];
        par ^= b;
        if (i < n) word[i] = b;
        if (i == total - 1)
          queue_period(b, 1'b0, 1'b0, 1'b1, word, with_par ? par : 1'b0, row);
        else
          queue_period(b, 1'b0, 1'b0, 1'b0, '0, 1'b0, row);
      end
      line_owned = 1'b0;
    end
  endfunction

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, name, got, want);
    end
  endtask

  task automatic add_row(input opcode_t op, input logic [5:0] bits,
                         input logic [31:0] wdata, input logic [32:0] tbits,
                         input int gold_len, input logic [31:0] gold_rdata,
                         input logic gold_perr);
    swd_row_t r;
    r.req.op     = op;
    r.req.bits   = bits;
    r.req.wdata  = wdata;
    r.req.tbits  = tbits;
    r.gold_len   = gold_len;
    r.gold_rdata = gold_rdata;
    r.gold_perr  = gold_perr;
    script.push_back(r);
  endtask

  // Offer one request and hold it until accepted; enter and leave on a falling edge
  task automatic offer_request(input swd_req_t r, input int row);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode      <= r.op;
    bit_count   <= r.bits;
    write_data  <= r.wdata;
    target_bits <= r.tbits;
    cur_row     = row;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  // Predict on each accepted request, check each accepted line period
  always @(posedge clk) begin
    line_period_t want;
    swd_req_t     req;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        req.op    = opcode_t'(opcode);
        req.bits  = bit_count;
        req.wdata = write_data;
        req.tbits = target_bits;
        predict_periods(req, cur_row);
      end
      if (out_valid && !out_stall) begin
        if (periods_due.size() == 0) begin
          compare_field("unexpected line period", 32'd1, 32'd0);
        end else begin
          want = periods_due.pop_front();
          compare_field("line_level", line_level, want.level);
          compare_field("drive_enable", drive_enable, want.drive);
          compare_field("turnaround", turnaround, want.turn);
          compare_field("last", last, want.last);
          compare_field("read_data", read_data, want.rdata);
          compare_field("parity_error", parity_error, want.perr);
          period_idx++;
          if (want.last) begin
            // typed-in answers for the directed rows
            if (want.row >= 0 && script[want.row].gold_len != 0) begin
              compare_field("request length", period_idx, script[want.row].gold_len);
              compare_field("final read_data", read_data, script[want.row].gold_rdata);
              compare_field("final parity_error", parity_error,
                            script[want.row].gold_perr);
            end
            period_idx = 0;
          end
        end
      end
    end
  end

  // Stall the result side at random, with one long hold-off on request
  initial begin
    int len;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        len = HOLD_OFF;
        hold_off_req = 1'b0;
      end else begin
        len = idle_len();
      end
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Abort when nothing moves for too long
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("swd_bit_sequencer_unit verification failed");
    $finish;
  end

  initial begin
    swd_req_t r;
    int       pick;

    // directed rows: extremes, each opcode, both turnarounds, odd bit counts
    add_row(OP_WRITE_PAR, 6'd32, 32'hFFFF_FFFF, 33'h0,           34, 32'h0,         1'b0);
    add_row(OP_READ_PAR,  6'd32, 32'h0,         33'h1_FFFF_FFFF, 34, 32'hFFFF_FFFF, 1'b1);
    add_row(OP_READ,      6'd1,  32'h0,         33'h0,           1,  32'h0,         1'b0);
    add_row(OP_READ,      6'd1,  32'h0,         33'h1,           1,  32'h1,         1'b0);
    add_row(OP_WRITE,     6'd1,  32'h0,         33'h0,           2,  32'h0,         1'b0);
    add_row(OP_WRITE_PAR, 6'd1,  32'h1,         33'h0,           2,  32'h0,         1'b0);
    add_row(OP_READ_PAR,  6'd8,  32'h0,         33'h1A5,         10, 32'hA5,        1'b1);
    add_row(OP_READ_PAR,  6'd8,  32'h0,         33'h0A5,         9,  32'hA5,        1'b0);
    add_row(OP_READ,      6'd0,  32'h0,         33'h1_FFFF_FFFF, 1,  32'h1,         1'b0);
    add_row(OP_READ,      6'd63, 32'h0,         33'h1_FFFF_FFFF, 32, 32'hFFFF_FFFF, 1'b0);
    add_row(OP_READ_PAR,  6'd33, 32'h0,         33'h1_0000_0000, 33, 32'h0,         1'b1);
    add_row(OP_WRITE,     6'd63, 32'hA5A5_A5A5, 33'h0,           33, 32'h0,         1'b0);
    add_row(OP_WRITE,     6'd0,  32'hFFFF_FFFE, 33'h0,           1,  32'h0,         1'b0);
    add_row(OP_READ,      6'd16, 32'h0,         33'h1_DEAD_1234, 17, 32'h1234,      1'b0);
    add_row(OP_WRITE_PAR, 6'd32, 32'h0,         33'h0,           34, 32'h0,         1'b0);
    add_row(OP_WRITE,     6'd32, 32'h8000_0001, 33'h0,           0,  32'h0,         1'b0);
    add_row(OP_READ_PAR,  6'd1,  32'h0,         33'h3,           3,  32'h1,         1'b0);
    add_row(OP_READ_PAR,  6'd31, 32'h0,         33'h1_5555_5555, 0,  32'h0,         1'b0);
    add_row(OP_WRITE_PAR, 6'd16, 32'h0000_8001, 33'h0,           0,  32'h0,         1'b0);
    add_row(OP_WRITE_PAR, 6'd7,  32'h0000_007F, 33'h0,           0,  32'h0,         1'b0);
    add_row(OP_READ,      6'd32, 32'h0,         33'h0,           33, 32'h0,         1'b0);

    // hold reset, then release it on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) offer_request(script[i].req, i);

    // random requests; one long receiver hold-off and one run without gaps
    for (int k = 0; k < RANDOM_REQS; k++) begin
      if (k == 40) hold_off_req = 1'b1;
      calm = (k >= 100 && k < 130);
      r.op = opcode_t'($urandom_range(0, 3));
      pick = $urandom_range(0, 19);
      if (pick == 0) r.bits = 6'd0;
      else if (pick == 1) r.bits = 6'($urandom_range(33, 63));
      else r.bits = 6'($urandom_range(1, 32));
      r.wdata = $urandom;
      r.tbits[31:0] = $urandom;
      r.tbits[32] = 1'($urandom_range(0, 1));
      offer_request(r, -1);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain what is still due, then watch for strays
    wait (periods_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && periods_due.size() == 0)
      $display("swd_bit_sequencer_unit verification clean");
    else
      $display("swd_bit_sequencer_unit verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/swd_pkg.sv
src/swd_ctrl.sv
src/swd_datapath.sv
src/swd_bit_sequencer_unit.sv
src/swd_checker.sv
tb/swd_bit_sequencer_unit_test.sv
